[hdl/first_fit_partition_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit partition allocator
// Shared forms of the concurrent checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("ffpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("ffpa assertion failed");

`endif

[hdl/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit partition allocator package
// Sizes, command and status types shared by the allocator modules.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_WIDTH     = 16;

    localparam int OPC_W  = 2;
    localparam int INSZ_W = 16;
    localparam int INIX_W = 4;
    localparam int CFG_W  = 5;
    localparam int STAT_W = 2;

    localparam int IDX_W  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(NUM_PARTITIONS + 1);
    localparam int CMP_W  = CNT_W + CFG_W;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SETSIZE = 2'd2,
        OP_UNUSED  = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_ISFREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_RELEASE,
        K_SET,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [SIZE_WIDTH-1:0]  size;
        logic [IDX_W-1:0]       idx;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

[hdl/ffpa_front.sv]
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts requests and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module ffpa_front
    import ffpa_pkg::*;
(
    input  logic              start,
    output logic              busy,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [INSZ_W-1:0] i_size_value,
    input  logic [INIX_W-1:0] i_partition_index,
    input  logic [CNT_W-1:0]  i_active,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [CMP_W-1:0] idx_ext;

    assign busy    = i_q_stat.full;
    assign o_push  = start && !i_q_stat.full;
    assign idx_ext = CMP_W'(i_partition_index);

    always_comb begin
        o_cmd.size = SIZE_WIDTH'(i_size_value);
        o_cmd.idx  = IDX_W'(idx_ext);
        case (t_opcode'(i_opcode))
            OP_ALLOC: begin
                o_cmd.kind = K_ALLOC;
            end
            OP_RELEASE: begin
                o_cmd.kind = (idx_ext < CMP_W'(i_active)) ? K_RELEASE : K_REJECT;
            end
            OP_SETSIZE: begin
                o_cmd.kind = (idx_ext < CMP_W'(NUM_PARTITIONS)) ? K_SET : K_REJECT;
            end
            default: begin
                o_cmd.kind = K_REJECT;
            end
        endcase
    end

endmodule

[hdl/ffpa_queue.sv]
// ----------------------------------------------------------------------------
// Allocator command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ffpa_queue
    import ffpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/ffpa_back.sv]
// ----------------------------------------------------------------------------
// Allocator back end
// Holds partition sizes and free flags and carries out queued commands.
// ----------------------------------------------------------------------------
module ffpa_back
    import ffpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_active,
    input  t_q_stat            i_q_stat,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_done,
    output logic [STAT_W-1:0]  o_status,
    output logic [INIX_W-1:0]  o_chosen_partition
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PICK
    } t_state;

    t_state                    r_state;
    t_cmd                      r_cmd;
    logic [SIZE_WIDTH-1:0]     r_sizes [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] r_free;
    logic [NUM_PARTITIONS-1:0] r_match;
    logic [NUM_PARTITIONS-1:0] n_match;
    logic                      r_done;
    t_status                   r_status;
    logic [INIX_W-1:0]         r_chosen;
    logic [IDX_W-1:0]          pick_idx;
    logic                      pick_hit;

    assign o_pop              = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_chosen_partition = r_chosen;

    always_comb begin
        for (int i = 0; i < NUM_PARTITIONS; i++) begin
            n_match[i] = r_free[i] && (r_sizes[i] >= r_cmd.size)
                         && (CMP_W'(i) < CMP_W'(i_active));
        end
    end

    always_comb begin
        pick_idx = '0;
        pick_hit = 1'b0;
        for (int i = NUM_PARTITIONS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                pick_idx = IDX_W'(i);
                pick_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= '1;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_chosen <= '0;
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                r_sizes[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (!i_q_stat.empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.kind)
                        K_ALLOC: begin
                            r_done  <= 1'b0;
                            r_match <= n_match;
                            r_state <= S_PICK;
                        end
                        K_RELEASE: begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                            if (r_free[r_cmd.idx]) begin
                                r_status <= ST_ISFREE;
                                r_chosen <= '0;
                            end else begin
                                r_free[r_cmd.idx] <= 1'b1;
                                r_status <= ST_OK;
                                r_chosen <= INIX_W'(r_cmd.idx);
                            end
                        end
                        K_SET: begin
                            r_done            <= 1'b1;
                            r_state           <= S_IDLE;
                            r_sizes[r_cmd.idx] <= r_cmd.size;
                            r_free[r_cmd.idx] <= 1'b1;
                            r_status          <= ST_OK;
                            r_chosen          <= INIX_W'(r_cmd.idx);
                        end
                        default: begin
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                            r_status <= ST_BADIDX;
                            r_chosen <= '0;
                        end
                    endcase
                end
                S_PICK: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (pick_hit) begin
                        r_free[pick_idx] <= 1'b0;
                        r_status <= ST_OK;
                        r_chosen <= INIX_W'(pick_idx);
                    end else begin
                        r_status <= ST_NOFIT;
                        r_chosen <= '0;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/first_fit_partition_allocator_core.sv]
// ----------------------------------------------------------------------------
// First-fit partition allocator core
// Usage: a request (opcode, size, index) is taken on a clock edge with start
// high and busy low. Opcode 0 allocates the lowest active free partition
// whose size is at least the request, 1 releases a partition and 2 writes a
// partition size and marks it free.
// Each request gives one transaction on o_done, o_status and
// o_chosen_partition, valid for exactly one cycle.
// An accepted request is registered in the queue and taken into the back
// end in S_IDLE. Release, set-size and rejected requests finish in S_EXEC;
// an allocate registers the parallel compare there and makes the priority
// pick in S_PICK. A two-entry queue lets the front accept while the back
// works.
// The partition count register is written with i_cfg_we and i_cfg_data and
// should only change while no request is in flight.
// Reset clears the queue, marks every partition free with size zero and
// sets the partition count to 16. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "first_fit_partition_allocator_core_assert.svh"

module first_fit_partition_allocator_core
    import ffpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [INSZ_W-1:0] i_size_value,
    input  logic [INIX_W-1:0] i_partition_index,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [STAT_W-1:0] o_status,
    output logic [INIX_W-1:0] o_chosen_partition
);

    logic [CFG_W-1:0] r_partition_count;
    logic [CNT_W-1:0] active;
    logic             push;
    logic             pop;
    t_cmd             front_cmd;
    t_cmd             queue_cmd;
    t_q_stat          q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partition_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_partition_count <= i_cfg_data;
        end
    end

    assign active = (CMP_W'(r_partition_count) > CMP_W'(NUM_PARTITIONS))
                    ? CNT_W'(NUM_PARTITIONS) : CNT_W'(r_partition_count);

    ffpa_front u_front (
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_size_value      (i_size_value),
        .i_partition_index (i_partition_index),
        .i_active          (active),
        .i_q_stat          (q_stat),
        .o_push            (push),
        .o_cmd             (front_cmd)
    );

    ffpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    ffpa_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_active           (active),
        .i_q_stat           (q_stat),
        .i_cmd              (queue_cmd),
        .o_pop              (pop),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_chosen_partition (o_chosen_partition)
    );

    `FFPA_ASSERT_SAME(a_fail_no_index, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_chosen_partition == '0)
    `FFPA_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, !q_stat.empty)
    `FFPA_ASSERT_NEXT(a_done_spaced, i_clk, i_rst_n, o_done, !o_done)
    `FFPA_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, pop, !q_stat.empty)

endmodule

[bench/first_fit_partition_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// First-fit partition allocator core testbench
// Drives allocate, release and set-size commands through the start/busy
// handshake. A directed table covers the reset state, the size extremes,
// every status code and the count edge cases. Random phases then run under
// several partition counts. Typed rows are checked against their listed
// outcome, other results against an in-bench model of the partition table.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_core_tb
    import ffpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 27;
    localparam int N_PHASES     = 8;

    typedef struct packed {
        t_status           st;
        logic [INIX_W-1:0] part;
    } t_outcome;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  cfg;
        t_opcode           op;
        logic [INSZ_W-1:0] size;
        logic [INIX_W-1:0] idx;
        t_status           st;
        logic [INIX_W-1:0] part;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OPC_W-1:0]  i_opcode = '0;
    logic [INSZ_W-1:0] i_size_value = '0;
    logic [INIX_W-1:0] i_partition_index = '0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [INIX_W-1:0] o_chosen_partition;

    logic [SIZE_WIDTH-1:0] model_sizes [NUM_PARTITIONS];
    logic                  model_free  [NUM_PARTITIONS];
    logic [CFG_W-1:0]      model_count;

    t_outcome expected_outcomes [$];
    int       fault_count = 0;
    int       cycle_count = 0;
    logic     calm = 1'b0;

    t_dir_row dir_rows [N_DIRECTED] = '{
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h0001, 4'd0,  ST_NOFIT,  4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'hFFFF, 4'd0,  ST_ISFREE, 4'd0},
        '{ROW_TYPED, 5'd0,  OP_UNUSED,  16'hFFFF, 4'd15, ST_BADIDX, 4'd0},
        '{ROW_TYPED, 5'd0,  OP_SETSIZE, 16'hFFFF, 4'd15, ST_OK,     4'd15},
        '{ROW_TYPED, 5'd0,  OP_SETSIZE, 16'h8000, 4'd3,  ST_OK,     4'd3},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'hFFFF, 4'd0,  ST_OK,     4'd15},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h8000, 4'd0,  ST_OK,     4'd3},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h8000, 4'd0,  ST_NOFIT,  4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd15, ST_OK,     4'd15},
        '{ROW_ITEM,  5'd0,  OP_SETSIZE, 16'h5555, 4'd5,  ST_OK,     4'd0},
        '{ROW_ITEM,  5'd0,  OP_SETSIZE, 16'hAAAA, 4'd10, ST_OK,     4'd0},
        '{ROW_ITEM,  5'd0,  OP_ALLOC,   16'h5000, 4'd0,  ST_OK,     4'd0},
        '{ROW_ITEM,  5'd0,  OP_ALLOC,   16'h0001, 4'd0,  ST_OK,     4'd0},
        '{ROW_CFG,   5'd0,  OP_ALLOC,   16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h0000, 4'd0,  ST_NOFIT,  4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd0,  ST_BADIDX, 4'd0},
        '{ROW_TYPED, 5'd0,  OP_SETSIZE, 16'h0001, 4'd15, ST_OK,     4'd15},
        '{ROW_CFG,   5'd1,  OP_ALLOC,   16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd3,  ST_BADIDX, 4'd0},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_ALLOC,   16'h0000, 4'd0,  ST_NOFIT,  4'd0},
        '{ROW_CFG,   5'd31, OP_ALLOC,   16'h0000, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd3,  ST_OK,     4'd3},
        '{ROW_ITEM,  5'd0,  OP_ALLOC,   16'h0001, 4'd0,  ST_OK,     4'd0},
        '{ROW_TYPED, 5'd0,  OP_RELEASE, 16'h0000, 4'd15, ST_ISFREE, 4'd0}
    };

    logic [CFG_W-1:0] phase_counts [N_PHASES] = '{
        5'd16, 5'd1, 5'd4, 5'd0, 5'd9, 5'd17, 5'd31, 5'd12
    };

    first_fit_partition_allocator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_size_value       (i_size_value),
        .i_partition_index  (i_partition_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_chosen_partition (o_chosen_partition)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_partition_allocator_core_tb: done, errors");
            $finish;
        end
    end

    function automatic int active_parts();
        return (int'(model_count) > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(model_count);
    endfunction

    function automatic t_outcome predict_outcome(t_opcode op, logic [INSZ_W-1:0] sz,
                                                 logic [INIX_W-1:0] idx);
        t_outcome              r;
        int                    act;
        logic                  found;
        logic [SIZE_WIDTH-1:0] req;
        r.st  = ST_BADIDX;
        r.part = '0;
        act   = active_parts();
        found = 1'b0;
        req   = SIZE_WIDTH'(sz);
        case (op)
            OP_ALLOC: begin
                r.st = ST_NOFIT;
                for (int i = 0; i < act; i++) begin
                    if (!found && model_free[i] && model_sizes[i] >= req) begin
                        found = 1'b1;
                        model_free[i] = 1'b0;
                        r.st = ST_OK;
                        r.part = INIX_W'(i);
                    end
                end
            end
            OP_RELEASE: begin
                if (int'(idx) >= act) begin
                    r.st = ST_BADIDX;
                end else if (model_free[idx]) begin
                    r.st = ST_ISFREE;
                end else begin
                    model_free[idx] = 1'b1;
                    r.st = ST_OK;
                    r.part = idx;
                end
            end
            OP_SETSIZE: begin
                if (int'(idx) < NUM_PARTITIONS) begin
                    model_sizes[idx] = req;
                    model_free[idx] = 1'b1;
                    r.st = ST_OK;
                    r.part = idx;
                end
            end
            default: r.st = ST_BADIDX;
        endcase
        return r;
    endfunction

    task automatic random_request(output t_opcode op, output logic [INSZ_W-1:0] sz,
                                  output logic [INIX_W-1:0] idx);
        int   roll;
        int   act;
        int   pick;
        int   j;
        logic found;
        roll  = $urandom_range(99);
        act   = active_parts();
        pick  = (act > 0) ? $urandom_range(act - 1) : 0;
        found = 1'b0;
        sz    = INSZ_W'($urandom);
        idx   = INIX_W'($urandom);
        if (roll < 40) begin
            op = OP_ALLOC;
            case ($urandom_range(3))
                1: sz = INSZ_W'(model_sizes[pick]);
                2: sz = INSZ_W'(model_sizes[pick]) - INSZ_W'($urandom_range(1, 3));
                3: sz = INSZ_W'($urandom_range(15));
                default: ;
            endcase
        end else if (roll < 68) begin
            op = OP_RELEASE;
            if (act > 0 && $urandom_range(3) != 0) begin
                for (int k = 0; k < act; k++) begin
                    j = (pick + k) % act;
                    if (!found && !model_free[j]) begin
                        found = 1'b1;
                        idx = INIX_W'(j);
                    end
                end
            end
        end else if (roll < 95) begin
            op = OP_SETSIZE;
            if (act > 0 && $urandom_range(3) != 0) idx = INIX_W'(pick);
            case ($urandom_range(7))
                0: sz = '0;
                1: sz = '1;
                default: ;
            endcase
        end else begin
            op = OP_UNUSED;
        end
    endtask

    task automatic pause_sender();
        if (!calm && $urandom_range(99) < 37) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic issue(t_opcode op, logic [INSZ_W-1:0] sz, logic [INIX_W-1:0] idx,
                         logic typed, t_outcome typed_out);
        t_outcome pred;
        start             <= 1'b1;
        i_opcode          <= op;
        i_size_value      <= sz;
        i_partition_index <= idx;
        do @(posedge i_clk); while (busy);
        pred = predict_outcome(op, sz, idx);
        expected_outcomes.push_back(typed ? typed_out : pred);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_count = value;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                if (fault_count < 10)
                    $display("%t: unexpected transaction, status %0d partition %0d",
                             $realtime, o_status, o_chosen_partition);
                fault_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.st || o_chosen_partition !== want.part) begin
                    if (fault_count < 10)
                        $display("%t: mismatch, expected status %s partition %0d, %s %0d %s %0d",
                                 $realtime, want.st.name(), want.part,
                                 "got status", o_status, "partition", o_chosen_partition);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        t_outcome          want;
        t_opcode           op;
        logic [INSZ_W-1:0] sz;
        logic [INIX_W-1:0] idx;
        int                n_items;
        for (int i = 0; i < NUM_PARTITIONS; i++) begin
            model_sizes[i] = '0;
            model_free[i]  = 1'b1;
        end
        model_count = CFG_RESET;
        want = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_count(dir_rows[r].cfg);
            end else begin
                want.st   = dir_rows[r].st;
                want.part = dir_rows[r].part;
                pause_sender();
                issue(dir_rows[r].op, dir_rows[r].size, dir_rows[r].idx,
                      dir_rows[r].kind == ROW_TYPED, want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_count(phase_counts[p]);
            calm = (p == 5);
            n_items = (phase_counts[p] == 0) ? 15 : 55;
            repeat (n_items) begin
                pause_sender();
                random_request(op, sz, idx);
                issue(op, sz, idx, 1'b0, want);
            end
        end

        wait_idle();
        if (fault_count == 0) begin
            $display("first_fit_partition_allocator_core_tb: done, clean");
        end else begin
            $display("first_fit_partition_allocator_core_tb: done, errors");
        end
        $finish;
    end

endmodule
